### hw/rtl/rtdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtdpt_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned CODE_W     = 15;
    localparam int unsigned REF_W      = 12;
    localparam int unsigned RT_W       = 15;
    localparam int unsigned TEMP_W     = 16;
    localparam int unsigned ACC_W      = 96;
    localparam int unsigned MAG_FULL_W = 88;
    localparam int unsigned MAG_W      = 72;
    localparam int unsigned HORNER_N   = 5;
    localparam int unsigned DIV_N      = 16;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;

    localparam logic [REF_W-1:0] REF_RESET = 12'd430;

    // register index taken from paddr[2]
    localparam logic REG_REF_OHMS = 1'b0;

    // leading coefficient, value scaled by 10^17 at tenths of an ohm
    localparam logic [ACC_W-1:0] C_ACC_INIT = 96'd1597;

    // Horner constants; the last one folds in the offset and the half for rounding
    localparam logic [ACC_W-1:0] C_COEF [HORNER_N] = '{
        -96'sd2951000,
        -96'sd4784000000,
        96'sd26130000000000,
        96'sd221900000000000000,
        -96'sd241850000000000000000
    };

    localparam logic [MAG_W-1:0]      C_UNIT = 72'd100000000000000000;
    localparam logic [MAG_FULL_W-1:0] C_LIM  = 88'd3276900000000000000000;

    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [RT_W-1:0]   rt;
        logic [DIV_N-1:0]  q;
        logic [MAG_W-1:0]  mag;
    } t_div_data;

endpackage
`default_nettype wire

### hw/rtl/rtdpt_horner_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rtdpt_horner_cell #(
    parameter logic [rtdpt_pkg::ACC_W-1:0] COEF = '0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [rtdpt_pkg::ACC_W-1:0] i_acc,
    input  wire logic [rtdpt_pkg::RT_W-1:0]  i_rt,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [rtdpt_pkg::ACC_W-1:0]      o_acc,
    output logic [rtdpt_pkg::RT_W-1:0]       o_rt
);

    localparam int unsigned PP_W = 32 + rtdpt_pkg::RT_W;

    logic                          r_va;
    logic                          r_vb;
    logic [PP_W-1:0]               r_pp0;
    logic [PP_W-1:0]               r_pp1;
    logic [31:0]                   r_pp2;
    logic [rtdpt_pkg::RT_W-1:0]    r_rt_a;
    logic [rtdpt_pkg::RT_W-1:0]    r_rt_b;
    logic [rtdpt_pkg::ACC_W-1:0]   r_acc;
    logic [PP_W-1:0]               n_pp0;
    logic [PP_W-1:0]               n_pp1;
    logic [31:0]                   n_pp2;
    logic [rtdpt_pkg::ACC_W-1:0]   n_acc;
    logic                          w_stall_a;
    logic                          w_stall_b;

    assign w_stall_b = r_vb && i_stall;
    assign w_stall_a = r_va && w_stall_b;
    assign o_stall   = w_stall_a;

    always_comb begin
        n_pp0 = {{rtdpt_pkg::RT_W{1'b0}}, i_acc[31:0]} * {17'b0, i_rt};
        n_pp1 = {{rtdpt_pkg::RT_W{1'b0}}, i_acc[63:32]} * {17'b0, i_rt};
        n_pp2 = i_acc[95:64] * {17'b0, i_rt};
        n_acc = {{(rtdpt_pkg::ACC_W - PP_W){1'b0}}, r_pp0}
              + {{(rtdpt_pkg::ACC_W - PP_W - 32){1'b0}}, r_pp1, 32'b0}
              + {r_pp2, 64'b0}
              + COEF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (!w_stall_a) r_va <= i_valid;
            if (!w_stall_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_a) begin
            r_pp0  <= n_pp0;
            r_pp1  <= n_pp1;
            r_pp2  <= n_pp2;
            r_rt_a <= i_rt;
        end
        if (!w_stall_b) begin
            r_acc  <= n_acc;
            r_rt_b <= r_rt_a;
        end
    end

    assign o_valid = r_vb;
    assign o_acc   = r_acc;
    assign o_rt    = r_rt_b;

endmodule
`default_nettype wire

### hw/rtl/rtdpt_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rtdpt_div_cell #(
    parameter int unsigned K = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire rtdpt_pkg::t_div_data i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rtdpt_pkg::t_div_data      o_data
);

    localparam logic [rtdpt_pkg::MAG_W-1:0] D = rtdpt_pkg::C_UNIT << K;

    logic                 r_valid;
    rtdpt_pkg::t_div_data r_data;
    rtdpt_pkg::t_div_data n_data;
    logic                 w_ge;
    logic                 w_stall;

    assign w_stall = r_valid && i_stall;
    assign o_stall = w_stall;

    always_comb begin
        w_ge      = i_data.mag >= D;
        n_data    = i_data;
        n_data.q[K] = w_ge;
        if (w_ge) n_data.mag = i_data.mag - D;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!w_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### hw/rtl/rtd_code_to_pt100_temperature_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_rtd_word
// result    out        o_valid / i_stall  o_resistance_tenths, o_temp_tenths
// config    in         APB write/read     ref_ohms at byte address 0
//
// One word per cycle sustained while i_stall stays low, through the stage chain:
// two resistance stages, five Horner cells of two stages each, sign and
// range stages, sixteen quotient-bit cells and the output register.
// Reset clears all stage valid flags and loads ref_ohms with 430.
// A stall passes upstream in the same cycle through full stages only, so empty stages keep filling.
module rtd_code_to_pt100_temperature_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [rtdpt_pkg::WORD_W-1:0]        i_rtd_word,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [rtdpt_pkg::RT_W-1:0]               o_resistance_tenths,
    output logic signed [rtdpt_pkg::TEMP_W-1:0]      o_temp_tenths,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rtdpt_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [rtdpt_pkg::DATA_W-1:0]        pwdata,
    output logic [rtdpt_pkg::DATA_W-1:0]             prdata,
    output logic                                     pready
);

    localparam int unsigned HN = rtdpt_pkg::HORNER_N;
    localparam int unsigned DN = rtdpt_pkg::DIV_N;
    localparam int unsigned P_W = rtdpt_pkg::CODE_W + rtdpt_pkg::REF_W;
    localparam int unsigned T_W = P_W + 4;

    logic [rtdpt_pkg::REF_W-1:0]  r_ref;

    logic                         r_r1_valid;
    logic [P_W-1:0]               r_r1_prod;
    logic                         r_r2_valid;
    logic [rtdpt_pkg::RT_W-1:0]   r_r2_rt;
    logic [P_W-1:0]               n_r1_prod;
    logic [T_W-1:0]               w_r2_sum;
    logic [rtdpt_pkg::RT_W-1:0]   n_r2_rt;
    logic                         w_r1_stall;
    logic                         w_r2_stall;

    logic                         w_h_valid [HN+1];
    logic                         w_h_stall [HN+1];
    logic [rtdpt_pkg::ACC_W-1:0]  w_h_acc   [HN+1];
    logic [rtdpt_pkg::RT_W-1:0]   w_h_rt    [HN+1];

    logic                            r_s1_valid;
    logic                            r_s1_neg;
    logic [rtdpt_pkg::RT_W-1:0]      r_s1_rt;
    logic [rtdpt_pkg::MAG_FULL_W-1:0] r_s1_mag;
    logic [rtdpt_pkg::ACC_W-1:0]     w_s1_abs;
    logic                            w_s1_stall;
    logic                            r_s2_valid;
    rtdpt_pkg::t_div_data            r_s2_data;
    rtdpt_pkg::t_div_data            n_s2_data;
    logic                            w_s2_stall;

    logic                  w_d_valid [DN+1];
    logic                  w_d_stall [DN+1];
    rtdpt_pkg::t_div_data  w_d_data  [DN+1];

    logic                              r_o_valid;
    logic [rtdpt_pkg::RT_W-1:0]        r_o_rt;
    logic [rtdpt_pkg::TEMP_W-1:0]      r_o_temp;
    logic [rtdpt_pkg::TEMP_W-1:0]      n_o_temp;
    rtdpt_pkg::t_div_data              w_fin;
    logic                              w_o_stall;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= rtdpt_pkg::REF_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == rtdpt_pkg::REG_REF_OHMS) begin
            r_ref <= pwdata[rtdpt_pkg::REF_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == rtdpt_pkg::REG_REF_OHMS) begin
            prdata = {{(rtdpt_pkg::DATA_W - rtdpt_pkg::REF_W){1'b0}}, r_ref};
        end
    end

    // resistance stages
    assign w_r2_stall = r_r2_valid && w_h_stall[0];
    assign w_r1_stall = r_r1_valid && w_r2_stall;
    assign o_stall    = w_r1_stall;

    always_comb begin
        n_r1_prod = {{rtdpt_pkg::REF_W{1'b0}}, i_rtd_word[rtdpt_pkg::WORD_W-1:1]}
                  * {{rtdpt_pkg::CODE_W{1'b0}}, r_ref};
        w_r2_sum  = {1'b0, r_r1_prod, 3'b0} + {3'b0, r_r1_prod, 1'b0}
                  + T_W'(16384);
        n_r2_rt   = (w_r2_sum[T_W-1:15] > (T_W-15)'(32767))
                  ? {rtdpt_pkg::RT_W{1'b1}} : w_r2_sum[29:15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
            r_r2_valid <= 1'b0;
        end else begin
            if (!w_r1_stall) r_r1_valid <= i_valid;
            if (!w_r2_stall) r_r2_valid <= r_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_r1_stall) r_r1_prod <= n_r1_prod;
        if (!w_r2_stall) r_r2_rt   <= n_r2_rt;
    end

    // polynomial chain
    assign w_h_valid[0] = r_r2_valid;
    assign w_h_acc[0]   = rtdpt_pkg::C_ACC_INIT;
    assign w_h_rt[0]    = r_r2_rt;
    assign w_h_stall[HN] = w_s1_stall;

    for (genvar g = 0; g < HN; g++) begin : g_horner
        rtdpt_horner_cell #(
            .COEF (rtdpt_pkg::C_COEF[g])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_h_valid[g]),
            .o_stall (w_h_stall[g]),
            .i_acc   (w_h_acc[g]),
            .i_rt    (w_h_rt[g]),
            .o_valid (w_h_valid[g+1]),
            .i_stall (w_h_stall[g+1]),
            .o_acc   (w_h_acc[g+1]),
            .o_rt    (w_h_rt[g+1])
        );
    end

    // sign and range stages
    assign w_s2_stall = r_s2_valid && w_d_stall[0];
    assign w_s1_stall = r_s1_valid && w_s2_stall;

    always_comb begin
        w_s1_abs = w_h_acc[HN][rtdpt_pkg::ACC_W-1] ? (-w_h_acc[HN]) : w_h_acc[HN];
        n_s2_data.neg = r_s1_neg;
        n_s2_data.sat = r_s1_mag >= rtdpt_pkg::C_LIM;
        n_s2_data.rt  = r_s1_rt;
        n_s2_data.q   = '0;
        n_s2_data.mag = r_s1_mag[rtdpt_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (!w_s1_stall) r_s1_valid <= w_h_valid[HN];
            if (!w_s2_stall) r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_s1_stall) begin
            r_s1_neg <= w_h_acc[HN][rtdpt_pkg::ACC_W-1];
            r_s1_rt  <= w_h_rt[HN];
            r_s1_mag <= w_s1_abs[rtdpt_pkg::MAG_FULL_W-1:0];
        end
        if (!w_s2_stall) r_s2_data <= n_s2_data;
    end

    // quotient chain, most significant bit first
    assign w_d_valid[0]  = r_s2_valid;
    assign w_d_data[0]   = r_s2_data;
    assign w_d_stall[DN] = w_o_stall;

    for (genvar g = 0; g < DN; g++) begin : g_div
        rtdpt_div_cell #(
            .K (DN - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_d_valid[g]),
            .o_stall (w_d_stall[g]),
            .i_data  (w_d_data[g]),
            .o_valid (w_d_valid[g+1]),
            .i_stall (w_d_stall[g+1]),
            .o_data  (w_d_data[g+1])
        );
    end

    // output register
    assign w_o_stall = r_o_valid && i_stall;
    assign w_fin     = w_d_data[DN];

    always_comb begin
        if (!w_fin.neg) begin
            n_o_temp = (w_fin.sat || w_fin.q[DN-1]) ? 16'h7FFF : w_fin.q;
        end else begin
            n_o_temp = (w_fin.sat || w_fin.q[DN-1]) ? 16'h8000 : (-w_fin.q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!w_o_stall) begin
            r_o_valid <= w_d_valid[DN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_o_stall) begin
            r_o_rt   <= w_fin.rt;
            r_o_temp <= n_o_temp;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_resistance_tenths = r_o_rt;
    assign o_temp_tenths       = r_o_temp;

endmodule
`default_nettype wire

### hw/rtl/rtdpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rtdpt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_stall,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic [rtdpt_pkg::RT_W-1:0]         o_resistance_tenths,
    input wire logic signed [rtdpt_pkg::TEMP_W-1:0] o_temp_tenths
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result side is free");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_resistance_tenths)
                                  && $stable(o_temp_tenths)))
        else $error("stalled result changed");

    a_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_resistance_tenths <= 15'd900) |-> o_temp_tenths[15])
        else $error("low resistance gave non-negative temperature");

    a_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_resistance_tenths >= 15'd1100) |-> !o_temp_tenths[15])
        else $error("high resistance gave negative temperature");

endmodule

bind rtd_code_to_pt100_temperature_top rtdpt_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_resistance_tenths (o_resistance_tenths),
    .o_temp_tenths       (o_temp_tenths)
);
`default_nettype wire
